// ===== hdl/bxt_pkg.sv =====
// Package for the binary trie maximum-xor block: sizes, command and status codes,
// payload words and the node memory request bundle.
// No dependencies.
package bxt_pkg;

    localparam int KEY_BITS   = 32;
    localparam int NODE_COUNT = 65536;

    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int FREE_BITS  = $clog2(NODE_COUNT + 1);
    localparam int LEVEL_BITS = (KEY_BITS > 2) ? $clog2(KEY_BITS) : 1;
    localparam int LINK_BITS  = 2 * NODE_BITS;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_ALLOC,
        ST_FINISH
    } state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] key;
    } in_word_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] best_xor;
    } out_word_t;

    // Two child indices of one node; index zero means the child is absent.
    typedef logic [1:0][NODE_BITS-1:0] links_t;

    typedef struct packed {
        logic                 wr_en;
        logic                 rd_en;
        logic [NODE_BITS-1:0] addr;
        links_t               wdata;
    } node_req_t;

endpackage

// ===== hdl/bxt_node_ram.sv =====
// Node link memory of the trie: one entry of two child indices per pool slot.
// Depends on bxt_pkg. One access per cycle, read data registered.
module bxt_node_ram (
    input  logic                aclk,
    input  bxt_pkg::node_req_t  req,
    output bxt_pkg::links_t     rd_data
);

    bxt_pkg::links_t mem [bxt_pkg::NODE_COUNT];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data <= mem[req.addr];
        end
    end

endmodule

// ===== hdl/binary_trie_max_xor.sv =====
// Top level of the binary trie maximum-xor engine: command sequencer, root links,
// pool allocator and result register. Depends on bxt_pkg and bxt_node_ram.
//
//  channel | ports                        | word        | meaning
//  --------+------------------------------+-------------+-------------------------------
//  input   | s_valid, s_ready, s_data     | in_word_t   | insert key / query max xor
//  result  | m_valid, m_ready, m_data     | out_word_t  | status and best xor, one each
//
// A query or duplicate insert walks one step per key bit, each below the root on the
// node read of the step before, then finishes; an insert that adds nodes writes one
// new node per missing level; an empty query finishes at once; a dropped insert stops
// at its first missing link. One word is in work at a time. Reset clears root links
// and has-values flag and sets the free pointer to 1; node slots are written
// when allocated, before any read. A stalled result holds only the finish step.
module binary_trie_max_xor (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bxt_pkg::in_word_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bxt_pkg::out_word_t   m_data
);

    localparam int SUM_BITS = bxt_pkg::FREE_BITS + 1;

    bxt_pkg::state_t  state_reg, state_next;

    bxt_pkg::cmd_t                        cmd_reg, cmd_next;
    logic [bxt_pkg::KEY_BITS-1:0]         key_reg, key_next;
    logic [bxt_pkg::KEY_BITS-1:0]         best_reg, best_next;
    logic [bxt_pkg::LEVEL_BITS-1:0]       level_reg, level_next;
    logic [bxt_pkg::NODE_BITS-1:0]        node_reg, node_next;
    logic                                 at_root_reg, at_root_next;
    bxt_pkg::status_t                     status_reg, status_next;

    bxt_pkg::links_t                      root_links_reg, root_links_next;
    logic [bxt_pkg::FREE_BITS-1:0]        next_free_reg, next_free_next;
    logic                                 has_values_reg, has_values_next;

    logic                                 m_valid_reg;
    bxt_pkg::out_word_t                   m_data_reg;

    bxt_pkg::node_req_t                   req;
    bxt_pkg::links_t                      rd_data;

    // Per-level decision signals
    bxt_pkg::links_t                      cur_links;
    bxt_pkg::links_t                      parent_links;
    logic                                 key_bit;
    logic [bxt_pkg::NODE_BITS-1:0]        own_child;
    logic [bxt_pkg::NODE_BITS-1:0]        opp_child;
    logic                                 last_level;
    logic                                 pool_short;
    logic [SUM_BITS-1:0]                  pool_need;
    logic                                 in_accept;
    logic                                 out_free;
    logic                                 empty_query;

    bxt_node_ram u_node_ram (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    // Links of the current node: root register at the top level, else last read.
    assign cur_links  = at_root_reg ? root_links_reg : rd_data;
    assign key_bit    = key_reg[level_reg];
    assign own_child  = cur_links[key_bit];
    assign opp_child  = cur_links[~key_bit];
    assign last_level = (level_reg == '0);

    // Nodes still needed once a link is missing: one per remaining level.
    assign pool_need  = SUM_BITS'(next_free_reg) + SUM_BITS'(level_reg) + SUM_BITS'(1);
    assign pool_short = (pool_need > SUM_BITS'(bxt_pkg::NODE_COUNT));

    assign in_accept   = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign empty_query = (s_data.cmd == bxt_pkg::CMD_QUERY) && !has_values_reg;

    assign s_ready = (state_reg == bxt_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bxt_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next = empty_query ? bxt_pkg::ST_FINISH : bxt_pkg::ST_WALK;
                end
            end
            bxt_pkg::ST_WALK: begin
                if (cmd_reg == bxt_pkg::CMD_QUERY) begin
                    if (last_level) begin
                        state_next = bxt_pkg::ST_FINISH;
                    end
                end else if (own_child == '0) begin
                    state_next = pool_short ? bxt_pkg::ST_FINISH : bxt_pkg::ST_ALLOC;
                end else if (last_level) begin
                    state_next = bxt_pkg::ST_FINISH;
                end
            end
            bxt_pkg::ST_ALLOC: begin
                if (last_level) begin
                    state_next = bxt_pkg::ST_FINISH;
                end
            end
            bxt_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = bxt_pkg::ST_IDLE;
                end
            end
            default: state_next = bxt_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory requests
    always_comb begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        best_next       = best_reg;
        level_next      = level_reg;
        node_next       = node_reg;
        at_root_next    = at_root_reg;
        status_next     = status_reg;
        root_links_next = root_links_reg;
        next_free_next  = next_free_reg;
        has_values_next = has_values_reg;
        parent_links    = cur_links;
        req             = '0;

        unique case (state_reg)
            bxt_pkg::ST_IDLE: begin
                if (in_accept) begin
                    cmd_next     = s_data.cmd;
                    key_next     = bxt_pkg::KEY_BITS'(s_data.key);
                    best_next    = '0;
                    level_next   = bxt_pkg::LEVEL_BITS'(bxt_pkg::KEY_BITS - 1);
                    at_root_next = 1'b1;
                    status_next  = empty_query ? bxt_pkg::STAT_EMPTY : bxt_pkg::STAT_OK;
                end
            end
            bxt_pkg::ST_WALK: begin
                if (cmd_reg == bxt_pkg::CMD_QUERY) begin
                    // Take the opposite branch when it exists.
                    if (opp_child != '0) begin
                        best_next[level_reg] = 1'b1;
                        node_next = opp_child;
                    end else begin
                        node_next = own_child;
                    end
                    if (!last_level) begin
                        req.rd_en    = 1'b1;
                        req.addr     = node_next;
                        level_next   = level_reg - 1'b1;
                        at_root_next = 1'b0;
                    end
                end else if (own_child == '0) begin
                    if (pool_short) begin
                        // Drop the whole insert.
                        status_next = bxt_pkg::STAT_FULL;
                    end else begin
                        // Hook the first new node under the current node.
                        parent_links[key_bit] = next_free_reg[bxt_pkg::NODE_BITS-1:0];
                        if (at_root_reg) begin
                            root_links_next = parent_links;
                        end else begin
                            req.wr_en = 1'b1;
                            req.addr  = node_reg;
                            req.wdata = parent_links;
                        end
                    end
                end else if (last_level) begin
                    // Key already stored.
                    has_values_next = 1'b1;
                end else begin
                    req.rd_en    = 1'b1;
                    req.addr     = own_child;
                    node_next    = own_child;
                    level_next   = level_reg - 1'b1;
                    at_root_next = 1'b0;
                end
            end
            bxt_pkg::ST_ALLOC: begin
                // Write one fresh node per cycle, each but the last linking to the next slot.
                req.wr_en = 1'b1;
                req.addr  = next_free_reg[bxt_pkg::NODE_BITS-1:0];
                req.wdata = '0;
                if (!last_level) begin
                    req.wdata[key_reg[level_reg - 1'b1]] =
                        bxt_pkg::NODE_BITS'(next_free_reg + 1'b1);
                    level_next = level_reg - 1'b1;
                end else begin
                    has_values_next = 1'b1;
                end
                next_free_next = next_free_reg + 1'b1;
            end
            bxt_pkg::ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bxt_pkg::ST_IDLE;
            root_links_reg <= '0;
            next_free_reg  <= bxt_pkg::FREE_BITS'(1);
            has_values_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            root_links_reg <= root_links_next;
            next_free_reg  <= next_free_next;
            has_values_reg <= has_values_next;
            if (state_reg == bxt_pkg::ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        best_reg    <= best_next;
        level_reg   <= level_next;
        node_reg    <= node_next;
        at_root_reg <= at_root_next;
        status_reg  <= status_next;
        if (state_reg == bxt_pkg::ST_FINISH && out_free) begin
            m_data_reg.status   <= status_reg;
            m_data_reg.best_xor <= (status_reg == bxt_pkg::STAT_OK
                                    && cmd_reg == bxt_pkg::CMD_QUERY)
                                   ? 32'(best_reg) : 32'd0;
        end
    end

    // The node memory has one port: never read and write in one cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.wr_en && req.rd_en))
        else $error("node memory read and write collide");

    // The free pointer never runs past the pool.
    assert property (@(posedge aclk) disable iff (!aresetn)
        next_free_reg <= bxt_pkg::FREE_BITS'(bxt_pkg::NODE_COUNT))
        else $error("node pool overrun");

    // Below the root, every walk step uses data read in the cycle before.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bxt_pkg::ST_WALK && !at_root_reg) |-> $past(req.rd_en))
        else $error("walk step without a node read");

    // Allocation only happens for an insert and advances the pool by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bxt_pkg::ST_ALLOC) |=> (next_free_reg == $past(next_free_reg) + 1'b1))
        else $error("allocation did not advance the pool");

endmodule

// ===== sim/binary_trie_max_xor_tb.sv =====
// Self-checking testbench for binary_trie_max_xor: drives insert and query words,
// predicts every result with a behavioral trie and checks status and best xor.
// Depends on bxt_pkg and the binary_trie_max_xor RTL.
`timescale 1ns / 1ps

module binary_trie_max_xor_tb;

    localparam int HOLD_CYCLES  = 400;  // long result stall for the backpressure test
    localparam int SETTLE_LIMIT = 40;   // a little more than the slowest word

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    bxt_pkg::in_word_t   s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    bxt_pkg::out_word_t  m_data;

    binary_trie_max_xor u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Behavioral trie. Slot 0 holds the root's links, since a child index of 0
    // means absent and the pool never hands out slot 0.
    int unsigned trie_kids [bxt_pkg::NODE_COUNT][2];
    int unsigned next_free_slot  = 1;
    bit          trie_populated  = 1'b0;
    logic [31:0] held_keys [$];          // keys that really went into the trie

    bxt_pkg::out_word_t pending_results [$];    // predicted results, oldest first
    int          bad_results     = 0;

    // Idle percentages and the result-stall request, set by the test sequence.
    int          send_idle_pct   = 0;
    int          recv_idle_pct   = 0;
    int          hold_req        = 0;
    int          hold_seen       = 0;
    int          hold_left       = 0;

    // Drop key bits above KEY_BITS; missing high bits read as zero.
    function automatic logic [63:0] trim_key(logic [31:0] key);
        logic [63:0] k;
        k = {32'b0, key};
        if (bxt_pkg::KEY_BITS < 64)
            k &= (64'd1 << bxt_pkg::KEY_BITS) - 64'd1;
        return k;
    endfunction

    // Count the nodes an insert of this key still has to allocate.
    function automatic int nodes_needed(logic [31:0] key);
        logic [63:0] k;
        int unsigned node;
        k    = trim_key(key);
        node = 0;
        for (int lvl = bxt_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
            if (trie_kids[node][k[lvl]] == 0)
                return lvl + 1;
            node = trie_kids[node][k[lvl]];
        end
        return 0;
    endfunction

    // Apply one accepted word to the trie and return the result it must produce.
    function automatic bxt_pkg::out_word_t apply_trie_word(bxt_pkg::in_word_t w);
        bxt_pkg::out_word_t r;
        logic [63:0] k;
        logic [63:0] best;
        int          need;
        int unsigned node;
        int unsigned kid;
        r.status   = bxt_pkg::STAT_OK;
        r.best_xor = '0;
        k          = trim_key(w.key);
        node       = 0;
        if (w.cmd == bxt_pkg::CMD_INSERT) begin
            need = nodes_needed(w.key);
            if (next_free_slot + need > bxt_pkg::NODE_COUNT) begin
                r.status = bxt_pkg::STAT_FULL;  // dropped whole, nothing allocated
            end else begin
                for (int lvl = bxt_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
                    kid = trie_kids[node][k[lvl]];
                    if (kid == 0) begin
                        kid = next_free_slot;
                        next_free_slot++;
                        trie_kids[kid][0] = 0;
                        trie_kids[kid][1] = 0;
                        trie_kids[node][k[lvl]] = kid;
                    end
                    node = kid;
                end
                trie_populated = 1'b1;
                if (need > 0)
                    held_keys.push_back(w.key);
            end
        end else if (!trie_populated) begin
            r.status = bxt_pkg::STAT_EMPTY;
        end else begin
            best = '0;
            for (int lvl = bxt_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
                kid = trie_kids[node][~k[lvl]];
                if (kid != 0)
                    best[lvl] = 1'b1;           // opposite branch exists: take it
                else
                    kid = trie_kids[node][k[lvl]];
                node = kid;
            end
            r.best_xor = best[31:0];
        end
        return r;
    endfunction

    // Offer one word, hold it until accepted, then log its predicted result.
    task automatic send_word(input bxt_pkg::cmd_t cmd, input logic [31:0] key);
        bxt_pkg::in_word_t w;
        w.cmd = cmd;
        w.key = key;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        pending_results.push_back(apply_trie_word(w));
    endtask

    // Drop valid and wait for every predicted result, then a little longer.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_LIMIT) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_held_key();
        return held_keys[$urandom_range(held_keys.size() - 1)];
    endfunction

    // Result side: check each accepted word, then choose next cycle's m_ready.
    always @(posedge aclk) begin : result_check
        bxt_pkg::out_word_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word, status %0d best_xor %h",
                         $time, m_data.status, m_data.best_xor);
                bad_results++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, m_data.status);
                    bad_results++;
                end
                if (m_data.best_xor !== want.best_xor) begin
                    $display("%0t: best_xor mismatch, expected %h actual %h",
                             $time, want.best_xor, m_data.best_xor);
                    bad_results++;
                end
            end
        end
        // Start a long hold when the sequence asks for one, else idle at random.
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Queries before any insert must all report an empty trie.
    task automatic test_empty_queries();
        send_word(bxt_pkg::CMD_QUERY, 32'h0000_0000);
        send_word(bxt_pkg::CMD_QUERY, 32'hFFFF_FFFF);
        send_word(bxt_pkg::CMD_QUERY, 32'hA5A5_5A5A);
        send_word(bxt_pkg::CMD_QUERY, $urandom());
        drain_results();
    endtask

    // Extreme keys, duplicate inserts and queries against a tiny known set.
    task automatic test_directed_keys();
        send_word(bxt_pkg::CMD_INSERT, 32'h0000_0000);
        send_word(bxt_pkg::CMD_QUERY,  32'h0000_0000);
        send_word(bxt_pkg::CMD_INSERT, 32'hFFFF_FFFF);
        send_word(bxt_pkg::CMD_INSERT, 32'h0000_0000);   // duplicate: no allocation
        send_word(bxt_pkg::CMD_QUERY,  32'h0000_0000);
        send_word(bxt_pkg::CMD_QUERY,  32'hFFFF_FFFF);
        send_word(bxt_pkg::CMD_QUERY,  32'h8000_0000);
        send_word(bxt_pkg::CMD_QUERY,  32'h7FFF_FFFF);
        send_word(bxt_pkg::CMD_INSERT, 32'h8000_0000);
        send_word(bxt_pkg::CMD_INSERT, 32'h0000_0001);
        send_word(bxt_pkg::CMD_INSERT, 32'hFFFF_FFFF);   // duplicate
        send_word(bxt_pkg::CMD_QUERY,  32'h0000_0001);
        send_word(bxt_pkg::CMD_QUERY,  32'h5555_5555);
        send_word(bxt_pkg::CMD_QUERY,  32'hAAAA_AAAA);
        send_word(bxt_pkg::CMD_QUERY,  32'hFFFF_FFFE);
        drain_results();
    endtask

    // Mixed traffic: fresh keys, keys sharing a prefix with held ones,
    // duplicates, and queries near held keys or at the extremes.
    task automatic test_random_traffic(input int n_words, input int s_pct, input int r_pct);
        int          pick;
        logic [31:0] key;
        logic [31:0] near;
        send_idle_pct = s_pct;
        recv_idle_pct <= r_pct;
        repeat (n_words) begin
            pick = $urandom_range(99);
            key  = held_keys.size() ? pick_held_key() : $urandom();
            near = key ^ ($urandom() & (32'hFFFF_FFFF >> $urandom_range(1, 31)));
            if (pick < 40) begin
                send_word(bxt_pkg::CMD_INSERT, $urandom());
            end else if (pick < 52) begin
                send_word(bxt_pkg::CMD_INSERT, near);
            end else if (pick < 60) begin
                send_word(bxt_pkg::CMD_INSERT, key);
            end else if (pick < 80) begin
                send_word(bxt_pkg::CMD_QUERY, $urandom());
            end else if (pick < 93) begin
                send_word(bxt_pkg::CMD_QUERY, near);
            end else begin
                send_word(bxt_pkg::CMD_QUERY,
                          $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000);
            end
        end
        drain_results();
    endtask

    // Hold m_ready low for a long stretch while words keep coming, so the
    // result register fills and the block must stall its input.
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_req      <= hold_req + 1;
        repeat (10)
            send_word(bxt_pkg::cmd_t'($urandom_range(1)), $urandom());
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_queries();
        test_directed_keys();
        test_random_traffic(640, 19, 72);
        test_random_traffic(640, 72, 19);
        test_random_traffic(620, 0, 0);
        test_result_backpressure();
        if (bad_results == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Give up well past the slowest correct run.
    initial begin
        #12_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
